[src/sit_pkg.sv]
// Shared constants and types of the segment intersection test.
package sit_pkg;

  // Default coordinate width of one endpoint field
  localparam int COORD_BITS_DEFAULT = 16;

  // Relation between the two supporting lines
  typedef enum logic [1:0] {
    REL_CROSS    = 2'd0,
    REL_PARALLEL = 2'd1,
    REL_SAME     = 2'd2
  } rel_t;

  // Per-pair flags worked out in the first stage and carried down the pipe
  typedef struct packed {
    logic pt1;      // first segment has zero length
    logic pt2;      // second segment has zero length
    logic wx_zero;  // start points share the same x
    logic box_any;  // some endpoint lies in the other segment's box
    logic p_in_rs;  // first start point lies in the second box
    logic r_in_pq;  // second start point lies in the first box
  } flags_t;

endpackage

[src/sit_pair_if.sv]
// Valid/ready channel carrying one pair of segments per beat.
interface sit_pair_if #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x0;
  logic signed [COORD_BITS-1:0] first_y0;
  logic signed [COORD_BITS-1:0] first_x1;
  logic signed [COORD_BITS-1:0] first_y1;
  logic signed [COORD_BITS-1:0] second_x0;
  logic signed [COORD_BITS-1:0] second_y0;
  logic signed [COORD_BITS-1:0] second_x1;
  logic signed [COORD_BITS-1:0] second_y1;

  modport source (
    output valid, first_x0, first_y0, first_x1, first_y1,
           second_x0, second_y0, second_x1, second_y1,
    input  ready
  );
  modport sink (
    input  valid, first_x0, first_y0, first_x1, first_y1,
           second_x0, second_y0, second_x1, second_y1,
    output ready
  );
endinterface

[src/sit_result_if.sv]
// Valid/ready channel carrying one intersection result per beat.
interface sit_result_if;
  logic              valid;
  logic              ready;
  logic              touches;
  sit_pkg::rel_t     line_relation;

  modport source (output valid, touches, line_relation, input ready);
  modport sink (input valid, touches, line_relation, output ready);
endinterface

[src/sit_prep.sv]
// First stage: direction vectors, start offset and bounding box tests.
module sit_prep #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  sit_pair_if.sink                     pair,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [COORD_BITS:0]   d1x,
  output logic signed [COORD_BITS:0]   d1y,
  output logic signed [COORD_BITS:0]   d2x,
  output logic signed [COORD_BITS:0]   d2y,
  output logic signed [COORD_BITS:0]   wx,
  output logic signed [COORD_BITS:0]   wy,
  output sit_pkg::flags_t              flags
);

  localparam int C = COORD_BITS;

  logic                enable;
  logic signed [C:0]   d1x_next, d1y_next, d2x_next, d2y_next, wx_next, wy_next;
  logic                p_in_rs, q_in_rs, r_in_pq, s_in_pq;
  sit_pkg::flags_t     flags_next;

  // Closed interval test with the ends in either order
  function automatic logic between(input logic signed [C-1:0] v,
                                   input logic signed [C-1:0] a,
                                   input logic signed [C-1:0] b);
    between = (v >= a && v <= b) || (v >= b && v <= a);
  endfunction

  // Differences at one bit more than the coordinates
  always_comb begin
    d1x_next = {pair.first_x1[C-1], pair.first_x1} - {pair.first_x0[C-1], pair.first_x0};
    d1y_next = {pair.first_y1[C-1], pair.first_y1} - {pair.first_y0[C-1], pair.first_y0};
    d2x_next = {pair.second_x1[C-1], pair.second_x1}
             - {pair.second_x0[C-1], pair.second_x0};
    d2y_next = {pair.second_y1[C-1], pair.second_y1}
             - {pair.second_y0[C-1], pair.second_y0};
    wx_next  = {pair.second_x0[C-1], pair.second_x0} - {pair.first_x0[C-1], pair.first_x0};
    wy_next  = {pair.second_y0[C-1], pair.second_y0} - {pair.first_y0[C-1], pair.first_y0};
  end

  // Endpoint against the other segment's bounding box
  always_comb begin
    p_in_rs = between(pair.first_x0, pair.second_x0, pair.second_x1)
           && between(pair.first_y0, pair.second_y0, pair.second_y1);
    q_in_rs = between(pair.first_x1, pair.second_x0, pair.second_x1)
           && between(pair.first_y1, pair.second_y0, pair.second_y1);
    r_in_pq = between(pair.second_x0, pair.first_x0, pair.first_x1)
           && between(pair.second_y0, pair.first_y0, pair.first_y1);
    s_in_pq = between(pair.second_x1, pair.first_x0, pair.first_x1)
           && between(pair.second_y1, pair.first_y0, pair.first_y1);
    flags_next.pt1     = (d1x_next == '0) && (d1y_next == '0);
    flags_next.pt2     = (d2x_next == '0) && (d2y_next == '0);
    flags_next.wx_zero = (wx_next == '0);
    flags_next.box_any = p_in_rs | q_in_rs | r_in_pq | s_in_pq;
    flags_next.p_in_rs = p_in_rs;
    flags_next.r_in_pq = r_in_pq;
  end

  // Take a beat whenever the stage is empty or being drained
  assign enable     = !dn_valid || dn_ready;
  assign pair.ready = enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (enable) begin
      dn_valid <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable && pair.valid) begin
      d1x   <= d1x_next;
      d1y   <= d1y_next;
      d2x   <= d2x_next;
      d2y   <= d2y_next;
      wx    <= wx_next;
      wy    <= wy_next;
      flags <= flags_next;
    end
  end

endmodule

[src/sit_cross.sv]
// Second and third stages: the six products, then the three cross products.
module sit_cross #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic signed [COORD_BITS:0]     d1x,
  input  logic signed [COORD_BITS:0]     d1y,
  input  logic signed [COORD_BITS:0]     d2x,
  input  logic signed [COORD_BITS:0]     d2y,
  input  logic signed [COORD_BITS:0]     wx,
  input  logic signed [COORD_BITS:0]     wy,
  input  sit_pkg::flags_t                up_flags,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output logic signed [2*COORD_BITS+2:0] den,
  output logic signed [2*COORD_BITS+2:0] tn,
  output logic signed [2*COORD_BITS+2:0] un,
  output sit_pkg::flags_t                dn_flags
);

  localparam int C  = COORD_BITS;
  localparam int PW = 2 * C + 2;

  logic signed [C:0]    e1x, e1y, e2x, e2y;
  logic                 prod_valid;
  logic                 prod_enable;
  logic                 diff_enable;
  logic signed [PW-1:0] ma, mb, mc, md, me, mf;
  sit_pkg::flags_t      prod_flags;

  // Zero-length segments take the vertical direction
  always_comb begin
    e1x = up_flags.pt1 ? '0 : d1x;
    e1y = up_flags.pt1 ? {{C{1'b0}}, 1'b1} : d1y;
    e2x = up_flags.pt2 ? '0 : d2x;
    e2y = up_flags.pt2 ? {{C{1'b0}}, 1'b1} : d2y;
  end

  // Ready ripples back so bubbles close up
  assign diff_enable = !dn_valid || dn_ready;
  assign prod_enable = !prod_valid || diff_enable;
  assign up_ready    = prod_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      dn_valid   <= 1'b0;
    end else begin
      if (prod_enable) begin
        prod_valid <= up_valid;
      end
      if (diff_enable) begin
        dn_valid <= prod_valid;
      end
    end
  end

  // Register the products
  always_ff @(posedge clk) begin
    if (prod_enable && up_valid) begin
      ma         <= PW'(e1x) * PW'(e2y);
      mb         <= PW'(e1y) * PW'(e2x);
      mc         <= PW'(wx) * PW'(d2y);
      md         <= PW'(wy) * PW'(d2x);
      me         <= PW'(wx) * PW'(d1y);
      mf         <= PW'(wy) * PW'(d1x);
      prod_flags <= up_flags;
    end
  end

  // Subtract pairs one bit wider
  always_ff @(posedge clk) begin
    if (diff_enable && prod_valid) begin
      den      <= {ma[PW-1], ma} - {mb[PW-1], mb};
      tn       <= {mc[PW-1], mc} - {md[PW-1], md};
      un       <= {me[PW-1], me} - {mf[PW-1], mf};
      dn_flags <= prod_flags;
    end
  end

endmodule

[src/sit_decide.sv]
// Last stage: classify the lines, decide contact and hold the result beat.
module sit_decide #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic signed [2*COORD_BITS+2:0] den,
  input  logic signed [2*COORD_BITS+2:0] tn,
  input  logic signed [2*COORD_BITS+2:0] un,
  input  sit_pkg::flags_t                flags,
  sit_result_if.source                   res
);

  localparam int CW = 2 * COORD_BITS + 3;

  logic          enable;
  logic          den_zero, same_line, in_range;
  logic          touches_next;
  sit_pkg::rel_t rel_next;

  // Range test without negating: flip the compares when den is negative
  always_comb begin
    den_zero  = (den == '0);
    same_line = flags.pt1 ? flags.wx_zero : (un == '0);
    if (!den[CW-1]) begin
      in_range = !tn[CW-1] && (tn <= den) && !un[CW-1] && (un <= den);
    end else begin
      in_range = (tn[CW-1] || (tn == '0)) && (tn >= den)
              && (un[CW-1] || (un == '0)) && (un >= den);
    end
  end

  always_comb begin
    if (den_zero) begin
      if (same_line) begin
        rel_next     = sit_pkg::REL_SAME;
        touches_next = flags.box_any;
      end else begin
        rel_next     = sit_pkg::REL_PARALLEL;
        touches_next = 1'b0;
      end
    end else begin
      rel_next = sit_pkg::REL_CROSS;
      if (flags.pt1) begin
        touches_next = (tn == '0) && flags.p_in_rs;
      end else if (flags.pt2) begin
        touches_next = (un == '0) && flags.r_in_pq;
      end else begin
        touches_next = in_range;
      end
    end
  end

  // Output register: hold the beat until taken
  assign enable   = !res.valid || res.ready;
  assign up_ready = enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (enable) begin
      res.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable && up_valid) begin
      res.touches       <= touches_next;
      res.line_relation <= rel_next;
    end
  end

endmodule

[src/segment_intersection_test_unit.sv]
// Segment intersection test: top level joining the four pipeline stages.
//
// Takes one pair of 2D segments per beat and returns whether they share a
// point and how their supporting lines relate (crossing, parallel and
// distinct, or the same line). All tests are exact integer compares and
// cross products. The pipe is fully pipelined: a new pair may enter every
// cycle while the output is not stalled, so the sustained rate is one pair
// per clock. Each pair passes through the four register stages in turn: endpoint
// differences with box tests, the six signed (2*COORD_BITS+2)-bit products,
// the three cross-product subtractions, and the final compare and output
// register. Ready ripples back stage by stage, so empty stages keep taking
// pairs while a result waits on the output.
module segment_intersection_test_unit #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  sit_pair_if.sink     in_pair,
  sit_result_if.source out_result
);

  localparam int C = COORD_BITS;

  logic                  prep_valid, prep_ready;
  logic signed [C:0]     d1x, d1y, d2x, d2y, wx, wy;
  sit_pkg::flags_t       prep_flags;
  logic                  cross_valid, cross_ready;
  logic signed [2*C+2:0] den, tn, un;
  sit_pkg::flags_t       cross_flags;

  sit_prep #(.COORD_BITS(C)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .pair     (in_pair),
    .dn_valid (prep_valid),
    .dn_ready (prep_ready),
    .d1x      (d1x),
    .d1y      (d1y),
    .d2x      (d2x),
    .d2y      (d2y),
    .wx       (wx),
    .wy       (wy),
    .flags    (prep_flags)
  );

  sit_cross #(.COORD_BITS(C)) u_cross (
    .clk      (clk),
    .rst      (rst),
    .up_valid (prep_valid),
    .up_ready (prep_ready),
    .d1x      (d1x),
    .d1y      (d1y),
    .d2x      (d2x),
    .d2y      (d2y),
    .wx       (wx),
    .wy       (wy),
    .up_flags (prep_flags),
    .dn_valid (cross_valid),
    .dn_ready (cross_ready),
    .den      (den),
    .tn       (tn),
    .un       (un),
    .dn_flags (cross_flags)
  );

  sit_decide #(.COORD_BITS(C)) u_decide (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cross_valid),
    .up_ready (cross_ready),
    .den      (den),
    .tn       (tn),
    .un       (un),
    .flags    (cross_flags),
    .res      (out_result)
  );

endmodule
